>>> sv/radix_string_converter_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the radix string converter
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef RADIX_STRING_CONVERTER_ASSERT_SVH
`define RADIX_STRING_CONVERTER_ASSERT_SVH

// same-cycle implication
`define RSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rsc_pkg.sv
// ---------------------------------------------------------------------------
// rsc_pkg
// Shared constants, command/status types and digit helpers of the converter.
// ---------------------------------------------------------------------------
package rsc_pkg;

    // value width and derived sizes
    localparam int VALUE_BITS = 64;
    localparam int WIDE_W     = VALUE_BITS + 4;          // room for x16 product
    localparam int DIGIT_MAX  = VALUE_BITS;              // binary is the longest
    localparam int COUNT_W    = $clog2(DIGIT_MAX + 1);
    localparam int IDX_W      = $clog2(DIGIT_MAX);
    localparam int DIV_STEPS  = VALUE_BITS / 4;          // one nibble per step
    localparam int BIT_CNT_W  = $clog2(DIV_STEPS);

    // register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_IN_RADIX  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_RADIX = 1'd1;

    // radix select codes
    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_DEC = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    // ASCII anchors
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'd57;
    localparam logic [7:0] ASCII_UPA   = 8'd65;
    localparam logic [7:0] ASCII_UPF   = 8'd70;
    localparam logic [7:0] ASCII_ALPHA = 8'd55;          // 'A' - 10

    localparam logic [4:0] NO_DIGIT = 5'd16;

    // controller to datapath
    typedef struct packed {
        logic acc_en;      // accumulate the accepted character
        logic load;        // copy accumulator into the work register
        logic div_step;    // one nibble of the divide-by-ten loop
        logic digit_step;  // store one digit, advance the quotient
        logic emit_step;   // read one stored digit toward the output
        logic clr;         // clear accumulator and overflow for the next string
    } rsc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_dec;     // output radix is ten
        logic div_last;    // last nibble of the division
        logic conv_done;   // quotient zero or buffer full after this digit
        logic emit_last;   // one digit left to read
    } rsc_sts_t;

    // digit value of an ASCII code, NO_DIGIT if none
    function automatic logic [4:0] char_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
            t = c - ASCII_ZERO;
            return t[4:0];
        end
        if (c >= ASCII_UPA && c <= ASCII_UPF) begin
            t = c - ASCII_ALPHA;
            return t[4:0];
        end
        return NO_DIGIT;
    endfunction

    function automatic logic [4:0] radix_value(input logic [1:0] sel);
        logic [4:0] r;
        r = 5'd2;
        case (sel)
            RADIX_BIN: r = 5'd2;
            RADIX_OCT: r = 5'd8;
            RADIX_DEC: r = 5'd10;
            default:   r = 5'd16;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] digit_ascii(input logic [3:0] d);
        logic [7:0] w;
        w = {4'd0, d};
        return (d > 4'd9) ? w + ASCII_ALPHA : w + ASCII_ZERO;
    endfunction

endpackage

>>> sv/rsc_ctrl.sv
// ---------------------------------------------------------------------------
// rsc_ctrl
// Sequencer: accumulate, load, divide/digit loop, then digit readout.
// ---------------------------------------------------------------------------
module rsc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last_char,
    input  rsc_pkg::rsc_sts_t sts,
    output rsc_pkg::rsc_cmd_t cmd,
    output logic              busy
);
    import rsc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_DIGIT = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.acc_en = 1'b1;
                    if (last_char)
                        state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = sts.out_dec ? ST_DIV : ST_DIGIT;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                cmd.digit_step = 1'b1;
                if (sts.conv_done)
                    state_next = ST_EMIT;
                else if (sts.out_dec)
                    state_next = ST_DIV;
            end
            ST_EMIT:
            begin
                cmd.emit_step = 1'b1;
                if (sts.emit_last)
                begin
                    cmd.clr    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> sv/rsc_dp.sv
// ---------------------------------------------------------------------------
// rsc_dp
// Radix registers, accumulator, digit extraction, digit buffer and output.
// ---------------------------------------------------------------------------
`include "radix_string_converter_assert.svh"

module rsc_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [1:0]                         cfg_data,
    input  logic [7:0]                         char_code,
    input  rsc_pkg::rsc_cmd_t                  cmd,
    output rsc_pkg::rsc_sts_t                  sts,
    output logic                               result_valid,
    output logic [7:0]                         digit_char,
    output logic                               last_digit,
    output logic                               overflow
);
    import rsc_pkg::*;

    logic [1:0]            in_sel_reg;
    logic [1:0]            out_sel_reg;
    logic [VALUE_BITS-1:0] acc_reg;
    logic                  ovf_reg;
    logic [VALUE_BITS-1:0] work_reg;
    logic [VALUE_BITS-1:0] work_next;
    logic [3:0]            rem_reg;
    logic [3:0]            rem_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [3:0]            digit_buf [DIGIT_MAX];
    logic [3:0]            rd_digit_reg;
    logic                  valid_reg;
    logic                  last_reg;
    logic                  ovf_out_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sel_reg  <= RADIX_DEC;
            out_sel_reg <= RADIX_BIN;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_IN_RADIX)
                in_sel_reg <= cfg_data;
            else
                out_sel_reg <= cfg_data;
        end
    end

    // accumulate: value*radix + digit, wrap detected in the top nibble
    logic [4:0]        ch_val;
    logic              ch_ok;
    logic [WIDE_W-1:0] acc_w;
    logic [WIDE_W-1:0] prod;
    logic [WIDE_W-1:0] sum;

    always_comb
    begin
        ch_val = char_value(char_code);
        ch_ok  = (ch_val < radix_value(in_sel_reg));
        acc_w  = {4'd0, acc_reg};
        case (in_sel_reg)
            RADIX_BIN: prod = acc_w << 1;
            RADIX_OCT: prod = acc_w << 3;
            RADIX_DEC: prod = (acc_w << 3) + (acc_w << 1);
            default:   prod = acc_w << 4;
        endcase
        sum = prod + {{(WIDE_W-5){1'b0}}, ch_val};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.clr)
        begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.acc_en && ch_ok)
        begin
            acc_reg <= sum[VALUE_BITS-1:0];
            if (sum[WIDE_W-1:VALUE_BITS] != 4'd0)
                ovf_reg <= 1'b1;
        end
    end

    // digit of the current step and remaining quotient
    logic [3:0]            digit;
    logic [VALUE_BITS-1:0] quot;
    logic [7:0]            div_tmp;
    logic [15:0]           div_prod;
    logic [3:0]            div_q;
    logic [7:0]            div_r;

    always_comb
    begin
        case (out_sel_reg)
            RADIX_BIN:
            begin
                digit = {3'd0, work_reg[0]};
                quot  = work_reg >> 1;
            end
            RADIX_OCT:
            begin
                digit = {1'b0, work_reg[2:0]};
                quot  = work_reg >> 3;
            end
            RADIX_DEC:
            begin
                digit = rem_reg;
                quot  = work_reg;
            end
            default:
            begin
                digit = work_reg[3:0];
                quot  = work_reg >> 4;
            end
        endcase
        // long division by ten, one nibble per cycle, msb first;
        // remainder:nibble stays below 160, where x*205 >> 11 is exact
        div_tmp  = {rem_reg, work_reg[VALUE_BITS-1 -: 4]};
        div_prod = {8'd0, div_tmp} * 16'd205;
        div_q    = div_prod[14:11];
        div_r    = div_tmp - {1'b0, div_q, 3'd0} - {3'd0, div_q, 1'b0};
    end

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        if (cmd.load)
        begin
            work_next = acc_reg;
            rem_next  = 4'd0;
        end
        else if (cmd.div_step)
        begin
            work_next = {work_reg[VALUE_BITS-5:0], div_q};
            rem_next  = div_r[3:0];
        end
        else if (cmd.digit_step)
        begin
            work_next = quot;
            rem_next  = 4'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    // division step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_cnt_reg <= BIT_CNT_W'(DIV_STEPS - 1);
        else if (cmd.load || cmd.digit_step)
            bit_cnt_reg <= BIT_CNT_W'(DIV_STEPS - 1);
        else if (cmd.div_step)
            bit_cnt_reg <= bit_cnt_reg - BIT_CNT_W'(1);
    end

    // digit count: fills on digit steps, drains on emit steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.load)
            count_reg <= '0;
        else if (cmd.digit_step)
            count_reg <= count_reg + COUNT_W'(1);
        else if (cmd.emit_step)
            count_reg <= count_reg - COUNT_W'(1);
    end

    // digit buffer, least significant digit at index zero
    logic [COUNT_W-1:0] rd_pos;
    assign rd_pos = count_reg - COUNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.digit_step)
            digit_buf[count_reg[IDX_W-1:0]] <= digit;
        if (cmd.emit_step)
            rd_digit_reg <= digit_buf[rd_pos[IDX_W-1:0]];
    end

    // output beat registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cmd.emit_step;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_step)
        begin
            last_reg    <= (count_reg == COUNT_W'(1));
            ovf_out_reg <= ovf_reg;
        end
    end

    assign result_valid = valid_reg;
    assign digit_char   = digit_ascii(rd_digit_reg);
    assign last_digit   = last_reg;
    assign overflow     = ovf_out_reg;

    // status to the controller
    always_comb
    begin
        sts.out_dec   = (out_sel_reg == RADIX_DEC);
        sts.div_last  = (bit_cnt_reg == '0);
        sts.conv_done = (quot == '0) || (count_reg == COUNT_W'(DIGIT_MAX - 1));
        sts.emit_last = (count_reg == COUNT_W'(1));
    end

    `RSC_ASSERT_NOW(a_beat_from_read, result_valid, $past(cmd.emit_step), "beat without read")
    `RSC_ASSERT_NOW(a_buf_room, cmd.digit_step, count_reg < COUNT_W'(DIGIT_MAX), "digit buffer overrun")
    `RSC_ASSERT_NOW(a_emit_nonempty, cmd.emit_step, count_reg != '0, "readout of empty buffer")

endmodule

>>> sv/radix_string_converter.sv
// ---------------------------------------------------------------------------
// radix_string_converter
// ASCII digit string in one radix to ASCII digits in another, 64-bit value.
// ---------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  config    cfg_we                    cfg_index, cfg_data
//  input     start & !busy             char_code, last_char
//  result    result_valid (1 cycle)    digit_char, last_digit, overflow
//
//  A character that is not last is accumulated on acceptance; the next may follow at once.
//  A last character adds a load step, then per output digit a digit store
//  (radix 2/8/16) or 16 nibble steps of the divide by ten plus the digit
//  store (radix 10), then one readout per digit from the digit buffer;
//  each beat follows its readout in the next cycle.
//  Reset clears the radix registers to decimal in, binary out, and the value.
//  Results cannot be stalled; one beat per cycle during readout.
// ---------------------------------------------------------------------------
module radix_string_converter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [1:0]                      cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [7:0]                      char_code,
    input  logic                            last_char,
    output logic                            result_valid,
    output logic [7:0]                      digit_char,
    output logic                            last_digit,
    output logic                            overflow
);
    import rsc_pkg::*;

    rsc_cmd_t cmd;
    rsc_sts_t sts;

    // sequencer
    rsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_char (last_char),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    // datapath
    rsc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .char_code    (char_code),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .digit_char   (digit_char),
        .last_digit   (last_digit),
        .overflow     (overflow)
    );

endmodule
